FILE: sv/gzip_member_deframer_assert.svh
// Assertion macros used by the deframer back end (gzd_back).
`ifndef GZIP_MEMBER_DEFRAMER_ASSERT_SVH
`define GZIP_MEMBER_DEFRAMER_ASSERT_SVH

// Assert that an antecedent implies a consequent on the same edge.
`define GZD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gzd: implication failed");

// Assert that an antecedent implies a consequent on the next edge.
`define GZD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gzd: next-cycle check failed");

`endif

FILE: sv/gzd_pkg.sv
package gzd_pkg;

    typedef enum logic [2:0] {
        K_STREAM  = 3'd0,
        K_DECOMP  = 3'd1,
        K_INF_END = 3'd2,
        K_EOI     = 3'd3,
        K_INF_ERR = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        T_NONE     = 2'd0,
        T_INFLATER = 2'd1,
        T_CONSUMER = 2'd2
    } t_target;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_HDR_DONE  = 4'd1,
        EV_MEMBER_OK = 4'd2,
        EV_BAD_MAGIC = 4'd3,
        EV_HDR_CRC   = 4'd4,
        EV_CRC       = 4'd5,
        EV_SIZE      = 4'd6,
        EV_TRUNC     = 4'd7,
        EV_CLEAN_END = 4'd8,
        EV_INF_ERR   = 4'd9
    } t_event;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_BODY    = 2'd1,
        PH_TRAILER = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        HS_FIXED   = 3'd0,
        HS_XLEN_LO = 3'd1,
        HS_XLEN_HI = 3'd2,
        HS_EXTRA   = 3'd3,
        HS_NAME    = 3'd4,
        HS_COMMENT = 3'd5,
        HS_HCRC_LO = 3'd6,
        HS_HCRC_HI = 3'd7
    } t_hstep;

    localparam logic [7:0] ID1 = 8'h1f;
    localparam logic [7:0] ID2 = 8'h8b;
    localparam logic [7:0] CM_DEFLATE = 8'h08;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic [1:0] target;
        logic [7:0] out_byte;
        logic [3:0] event_res;
    } t_out_item;

    // CRC-32 over one byte, held in final (non-inverted) form.
    function automatic logic [31:0] crc_add(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = ~crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return ~c;
    endfunction

endpackage

FILE: sv/gzd_front.sv
// Front: take input beats and push them into a short queue.
module gzd_front #(
    parameter int DEPTH_LOG2 = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  gzd_pkg::t_in_item i_item,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output gzd_pkg::t_in_item o_q_item
);
    localparam int DEPTH = 1 << DEPTH_LOG2;

    gzd_pkg::t_in_item r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [DEPTH_LOG2:0]   r_cnt, n_cnt;
    logic push, pop;

    assign o_stall   = (r_cnt == DEPTH[DEPTH_LOG2:0]);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rd];

    always_comb begin
        n_wr  = push ? r_wr + 1'b1 : r_wr;
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + {{DEPTH_LOG2{1'b0}}, push} - {{DEPTH_LOG2{1'b0}}, pop};
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end
endmodule

FILE: sv/gzd_back.sv
// Back: header, body and trailer processing; registered result.
module gzd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  gzd_pkg::t_in_item  i_q_item,
    output logic               o_valid,
    input  logic               i_stall,
    output gzd_pkg::t_out_item o_item
);
    gzd_pkg::t_phase r_phase, n_phase;
    gzd_pkg::t_hstep r_hstep, n_hstep;
    logic [3:0]  r_fcnt, n_fcnt;
    logic [7:0]  r_flg, n_flg;
    logic [15:0] r_xleft, n_xleft;
    logic [7:0]  r_held, n_held;
    logic [31:0] r_hcrc, n_hcrc;
    logic [31:0] r_bcrc, n_bcrc;
    logic [31:0] r_bsize, n_bsize;
    logic [63:0] r_tbytes, n_tbytes;
    logic [3:0]  r_tcnt, n_tcnt;
    logic        r_failed, n_failed;
    logic        r_magic_bad, n_magic_bad;
    logic        r_ovalid, n_ovalid;
    gzd_pkg::t_out_item r_out, n_out;

    logic go;
    logic [7:0] b;
    logic [31:0] hcrc_upd;
    logic [15:0] xlen;

    assign o_q_pop = i_q_valid && (!r_ovalid || !i_stall);
    assign go = o_q_pop;
    assign b = i_q_item.data;
    assign hcrc_upd = gzd_pkg::crc_add(r_hcrc, b);
    assign xlen = {b, r_held};
    assign o_valid = r_ovalid;
    assign o_item = r_out;

    function automatic gzd_pkg::t_hstep next_step(input gzd_pkg::t_hstep from,
                                                  input logic [7:0] flg,
                                                  output logic done);
        done = 1'b0;
        if (from <= gzd_pkg::HS_XLEN_LO && flg[2]) return gzd_pkg::HS_XLEN_LO;
        if (from <= gzd_pkg::HS_NAME && flg[3]) return gzd_pkg::HS_NAME;
        if (from <= gzd_pkg::HS_COMMENT && flg[4]) return gzd_pkg::HS_COMMENT;
        if (from <= gzd_pkg::HS_HCRC_LO && flg[1]) return gzd_pkg::HS_HCRC_LO;
        done = 1'b1;
        return gzd_pkg::HS_FIXED;
    endfunction

    always_comb begin
        logic done;
        logic [3:0] fc1;
        gzd_pkg::t_hstep ns;
        logic [7:0] flg_eff;
        n_phase = r_phase; n_hstep = r_hstep; n_fcnt = r_fcnt; n_flg = r_flg;
        n_xleft = r_xleft; n_held = r_held; n_hcrc = r_hcrc; n_bcrc = r_bcrc;
        n_bsize = r_bsize; n_tbytes = r_tbytes; n_tcnt = r_tcnt;
        n_failed = r_failed; n_magic_bad = r_magic_bad;
        n_out = '0;
        done = 1'b0;
        fc1 = r_fcnt + 4'd1;
        ns = gzd_pkg::HS_FIXED;
        flg_eff = (r_fcnt == 4'd3) ? b : r_flg;
        if (go && !r_failed) begin
            case (i_q_item.kind)
                gzd_pkg::K_STREAM: begin
                    case (r_phase)
                        gzd_pkg::PH_HEADER: begin
                            case (r_hstep)
                                gzd_pkg::HS_FIXED: begin
                                    n_hcrc = hcrc_upd;
                                    if ((r_fcnt == 4'd0 && b != gzd_pkg::ID1) ||
                                        (r_fcnt == 4'd1 && b != gzd_pkg::ID2) ||
                                        (r_fcnt == 4'd2 && b != gzd_pkg::CM_DEFLATE))
                                        n_magic_bad = 1'b1;
                                    n_flg = flg_eff;
                                    n_fcnt = fc1;
                                    if (fc1 >= 4'd10) begin
                                        if (n_magic_bad) begin
                                            n_failed = 1'b1;
                                            n_out.event_res = gzd_pkg::EV_BAD_MAGIC;
                                        end else begin
                                            ns = next_step(gzd_pkg::HS_XLEN_LO, flg_eff, done);
                                        end
                                    end
                                end
                                gzd_pkg::HS_XLEN_LO: begin
                                    n_hcrc = hcrc_upd; n_held = b;
                                    n_hstep = gzd_pkg::HS_XLEN_HI;
                                end
                                gzd_pkg::HS_XLEN_HI: begin
                                    n_hcrc = hcrc_upd; n_xleft = xlen;
                                    if (xlen == 16'd0) ns = next_step(gzd_pkg::HS_NAME, r_flg, done);
                                    else n_hstep = gzd_pkg::HS_EXTRA;
                                end
                                gzd_pkg::HS_EXTRA: begin
                                    n_hcrc = hcrc_upd; n_xleft = r_xleft - 16'd1;
                                    if (n_xleft == 16'd0) ns = next_step(gzd_pkg::HS_NAME, r_flg, done);
                                end
                                gzd_pkg::HS_NAME: begin
                                    n_hcrc = hcrc_upd;
                                    if (b == 8'd0) ns = next_step(gzd_pkg::HS_COMMENT, r_flg, done);
                                end
                                gzd_pkg::HS_COMMENT: begin
                                    n_hcrc = hcrc_upd;
                                    if (b == 8'd0) ns = next_step(gzd_pkg::HS_HCRC_LO, r_flg, done);
                                end
                                gzd_pkg::HS_HCRC_LO: begin
                                    n_held = b; n_hstep = gzd_pkg::HS_HCRC_HI;
                                end
                                default: begin
                                    if ({b, r_held} != r_hcrc[15:0]) begin
                                        n_failed = 1'b1;
                                        n_out.event_res = gzd_pkg::EV_HDR_CRC;
                                    end else begin
                                        done = 1'b1;
                                    end
                                end
                            endcase
                            if (ns != gzd_pkg::HS_FIXED) n_hstep = ns;
                            if (done) begin
                                n_phase = gzd_pkg::PH_BODY;
                                n_bcrc = '0; n_bsize = '0;
                                n_out.event_res = gzd_pkg::EV_HDR_DONE;
                            end
                        end
                        gzd_pkg::PH_BODY: begin
                            n_out.target = gzd_pkg::T_INFLATER;
                            n_out.out_byte = b;
                        end
                        default: begin
                            n_tbytes = r_tbytes | ({56'd0, b} << {r_tcnt[2:0], 3'b000});
                            n_tcnt = r_tcnt + 4'd1;
                            if (n_tcnt >= 4'd8) begin
                                if (n_tbytes[31:0] != r_bcrc) begin
                                    n_failed = 1'b1;
                                    n_out.event_res = gzd_pkg::EV_CRC;
                                end else if (n_tbytes[63:32] != r_bsize) begin
                                    n_failed = 1'b1;
                                    n_out.event_res = gzd_pkg::EV_SIZE;
                                end else begin
                                    n_phase = gzd_pkg::PH_HEADER;
                                    n_hstep = gzd_pkg::HS_FIXED;
                                    n_fcnt = '0; n_hcrc = '0; n_magic_bad = 1'b0;
                                    n_out.event_res = gzd_pkg::EV_MEMBER_OK;
                                end
                            end
                        end
                    endcase
                end
                gzd_pkg::K_DECOMP: begin
                    if (r_phase == gzd_pkg::PH_BODY) begin
                        n_bcrc = gzd_pkg::crc_add(r_bcrc, b);
                        n_bsize = r_bsize + 32'd1;
                        n_out.target = gzd_pkg::T_CONSUMER;
                        n_out.out_byte = b;
                    end
                end
                gzd_pkg::K_INF_END: begin
                    if (r_phase == gzd_pkg::PH_BODY) begin
                        n_phase = gzd_pkg::PH_TRAILER;
                        n_tcnt = '0; n_tbytes = '0;
                    end
                end
                gzd_pkg::K_EOI: begin
                    if (r_phase == gzd_pkg::PH_HEADER && r_hstep == gzd_pkg::HS_FIXED &&
                        r_fcnt == 4'd0) begin
                        n_out.event_res = gzd_pkg::EV_CLEAN_END;
                    end else begin
                        n_failed = 1'b1;
                        n_out.event_res = gzd_pkg::EV_TRUNC;
                    end
                end
                gzd_pkg::K_INF_ERR: begin
                    if (r_phase == gzd_pkg::PH_BODY) begin
                        n_failed = 1'b1;
                        n_out.event_res = gzd_pkg::EV_INF_ERR;
                    end
                end
                default: ;
            endcase
        end
        n_ovalid = go ? 1'b1 : (r_ovalid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            r_phase <= gzd_pkg::PH_HEADER; r_hstep <= gzd_pkg::HS_FIXED;
            r_fcnt <= '0; r_flg <= '0; r_xleft <= '0; r_held <= '0;
            r_hcrc <= '0; r_bcrc <= '0; r_bsize <= '0; r_tbytes <= '0;
            r_tcnt <= '0; r_failed <= 1'b0; r_magic_bad <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_phase <= n_phase; r_hstep <= n_hstep; r_fcnt <= n_fcnt; r_flg <= n_flg;
            r_xleft <= n_xleft; r_held <= n_held; r_hcrc <= n_hcrc; r_bcrc <= n_bcrc;
            r_bsize <= n_bsize; r_tbytes <= n_tbytes; r_tcnt <= n_tcnt;
            r_failed <= n_failed; r_magic_bad <= n_magic_bad; r_ovalid <= n_ovalid;
        end
    end

`include "gzip_member_deframer_assert.svh"
    `GZD_ASSERT_NEXT(a_fail_sticky, i_clk, i_rst_n, r_failed, r_failed)
    `GZD_ASSERT_NEXT(a_quiet_after_fail, i_clk, i_rst_n, r_failed && go, r_out == '0)
    `GZD_ASSERT_IMPL(a_fwd_only_body, i_clk, i_rst_n,
        r_ovalid && r_out.target != gzd_pkg::T_NONE, r_out.event_res == gzd_pkg::EV_NONE)
endmodule

FILE: sv/gzip_member_deframer.sv
// gzip member deframer: parses multi-member gzip streams around an external
// inflater. Feed stream bytes (kind 0), decompressed bytes returned by the
// inflater (kind 1) and inflater done/error and end-of-input markers; every
// accepted beat yields exactly one result beat giving the routing target of
// the byte and any event (header done, member ok, clean end, or a sticky
// error). One beat per clock is sustained while i_stall is low; a beat
// passes the two-entry input queue, then the registered CRC/phase stage,
// whose per-byte CRC-32 update sets the clock period. Errors hold until reset.
module gzip_member_deframer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  gzd_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output gzd_pkg::t_out_item  o_item
);
    logic              q_valid, q_pop;
    gzd_pkg::t_in_item q_item;

    // accept and queue beats
    gzd_front #(.DEPTH_LOG2(1)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    // parse and route
    gzd_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_item(q_item),
        .o_valid, .i_stall, .o_item
    );
endmodule

FILE: tb/gzip_member_deframer_tb.sv
`timescale 1ns / 1ps

module gzip_member_deframer_tb;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    gzd_pkg::t_in_item  i_item;
    logic               o_valid;
    logic               i_stall;
    gzd_pkg::t_out_item o_item;

    gzip_member_deframer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Shadow copy of the deframer state, advanced once per accepted input beat.
    gzd_pkg::t_phase sh_phase;
    gzd_pkg::t_hstep sh_step;
    logic [3:0]  sh_fixed_cnt;
    logic [7:0]  sh_flags;
    logic [15:0] sh_extra_left;
    logic [7:0]  sh_low_byte;
    logic [31:0] sh_hdr_crc;
    logic [31:0] sh_body_crc;
    logic [31:0] sh_body_size;
    logic [63:0] sh_trailer;
    logic [3:0]  sh_trailer_cnt;
    logic        sh_failed;
    logic        sh_magic_bad;

    gzd_pkg::t_out_item expected_beats[$];
    int          fail_count;
    bit          stall_noise;

    // Bitwise CRC-32 in final (non-inverted) form; written afresh for the checker.
    function automatic logic [31:0] crc32_step(logic [31:0] crc, logic [7:0] b);
        logic [31:0] r;
        r = ~crc;
        r[7:0] = r[7:0] ^ b;
        for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        return ~r;
    endfunction

    task automatic reset_shadow();
        sh_phase = gzd_pkg::PH_HEADER;
        sh_step = gzd_pkg::HS_FIXED;
        sh_fixed_cnt = '0;
        sh_flags = '0;
        sh_extra_left = '0;
        sh_low_byte = '0;
        sh_hdr_crc = '0;
        sh_body_crc = '0;
        sh_body_size = '0;
        sh_trailer = '0;
        sh_trailer_cnt = '0;
        sh_failed = 1'b0;
        sh_magic_bad = 1'b0;
    endtask

    // Jump to the first optional header field present at or after 'from';
    // enter the body when none is left.
    function automatic gzd_pkg::t_event advance_field(gzd_pkg::t_hstep from);
        if (from <= gzd_pkg::HS_XLEN_LO && sh_flags[2]) begin
            sh_step = gzd_pkg::HS_XLEN_LO;
            return gzd_pkg::EV_NONE;
        end
        if (from <= gzd_pkg::HS_NAME && sh_flags[3]) begin
            sh_step = gzd_pkg::HS_NAME;
            return gzd_pkg::EV_NONE;
        end
        if (from <= gzd_pkg::HS_COMMENT && sh_flags[4]) begin
            sh_step = gzd_pkg::HS_COMMENT;
            return gzd_pkg::EV_NONE;
        end
        if (from <= gzd_pkg::HS_HCRC_LO && sh_flags[1]) begin
            sh_step = gzd_pkg::HS_HCRC_LO;
            return gzd_pkg::EV_NONE;
        end
        sh_phase = gzd_pkg::PH_BODY;
        sh_body_crc = '0;
        sh_body_size = '0;
        return gzd_pkg::EV_HDR_DONE;
    endfunction

    function automatic gzd_pkg::t_event header_beat(logic [7:0] b);
        case (sh_step)
            gzd_pkg::HS_FIXED: begin
                sh_hdr_crc = crc32_step(sh_hdr_crc, b);
                if ((sh_fixed_cnt == 0 && b != gzd_pkg::ID1) ||
                    (sh_fixed_cnt == 1 && b != gzd_pkg::ID2) ||
                    (sh_fixed_cnt == 2 && b != gzd_pkg::CM_DEFLATE))
                    sh_magic_bad = 1'b1;
                if (sh_fixed_cnt == 3) sh_flags = b;
                sh_fixed_cnt = sh_fixed_cnt + 1'b1;
                if (sh_fixed_cnt >= 10) begin
                    if (sh_magic_bad) begin
                        sh_failed = 1'b1;
                        return gzd_pkg::EV_BAD_MAGIC;
                    end
                    return advance_field(gzd_pkg::HS_XLEN_LO);
                end
                return gzd_pkg::EV_NONE;
            end
            gzd_pkg::HS_XLEN_LO: begin
                sh_hdr_crc = crc32_step(sh_hdr_crc, b);
                sh_low_byte = b;
                sh_step = gzd_pkg::HS_XLEN_HI;
                return gzd_pkg::EV_NONE;
            end
            gzd_pkg::HS_XLEN_HI: begin
                sh_hdr_crc = crc32_step(sh_hdr_crc, b);
                sh_extra_left = {b, sh_low_byte};
                if (sh_extra_left == 0) return advance_field(gzd_pkg::HS_NAME);
                sh_step = gzd_pkg::HS_EXTRA;
                return gzd_pkg::EV_NONE;
            end
            gzd_pkg::HS_EXTRA: begin
                sh_hdr_crc = crc32_step(sh_hdr_crc, b);
                sh_extra_left = sh_extra_left - 1'b1;
                if (sh_extra_left == 0) return advance_field(gzd_pkg::HS_NAME);
                return gzd_pkg::EV_NONE;
            end
            gzd_pkg::HS_NAME: begin
                sh_hdr_crc = crc32_step(sh_hdr_crc, b);
                return (b == 0) ? advance_field(gzd_pkg::HS_COMMENT) : gzd_pkg::EV_NONE;
            end
            gzd_pkg::HS_COMMENT: begin
                sh_hdr_crc = crc32_step(sh_hdr_crc, b);
                return (b == 0) ? advance_field(gzd_pkg::HS_HCRC_LO) : gzd_pkg::EV_NONE;
            end
            gzd_pkg::HS_HCRC_LO: begin
                sh_low_byte = b;
                sh_step = gzd_pkg::HS_HCRC_HI;
                return gzd_pkg::EV_NONE;
            end
            default: begin
                if ({b, sh_low_byte} != sh_hdr_crc[15:0]) begin
                    sh_failed = 1'b1;
                    return gzd_pkg::EV_HDR_CRC;
                end
                sh_phase = gzd_pkg::PH_BODY;
                sh_body_crc = '0;
                sh_body_size = '0;
                return gzd_pkg::EV_HDR_DONE;
            end
        endcase
    endfunction

    function automatic gzd_pkg::t_event trailer_beat(logic [7:0] b);
        sh_trailer[8*sh_trailer_cnt[2:0] +: 8] = b;
        sh_trailer_cnt = sh_trailer_cnt + 1'b1;
        if (sh_trailer_cnt < 8) return gzd_pkg::EV_NONE;
        if (sh_trailer[31:0] != sh_body_crc) begin
            sh_failed = 1'b1;
            return gzd_pkg::EV_CRC;
        end
        if (sh_trailer[63:32] != sh_body_size) begin
            sh_failed = 1'b1;
            return gzd_pkg::EV_SIZE;
        end
        // Member complete: rearm the header parser for the next one.
        sh_phase = gzd_pkg::PH_HEADER;
        sh_step = gzd_pkg::HS_FIXED;
        sh_fixed_cnt = '0;
        sh_hdr_crc = '0;
        sh_magic_bad = 1'b0;
        return gzd_pkg::EV_MEMBER_OK;
    endfunction

    // Work out the one result beat that an input beat causes.
    function automatic gzd_pkg::t_out_item deframe_beat(gzd_pkg::t_in_item it);
        gzd_pkg::t_out_item r;
        r = '0;
        if (!sh_failed) begin
            case (it.kind)
                gzd_pkg::K_STREAM: begin
                    if (sh_phase == gzd_pkg::PH_HEADER) r.event_res = header_beat(it.data);
                    else if (sh_phase == gzd_pkg::PH_BODY) begin
                        r.target = gzd_pkg::T_INFLATER;
                        r.out_byte = it.data;
                    end else r.event_res = trailer_beat(it.data);
                end
                gzd_pkg::K_DECOMP: if (sh_phase == gzd_pkg::PH_BODY) begin
                    sh_body_crc = crc32_step(sh_body_crc, it.data);
                    sh_body_size = sh_body_size + 1;
                    r.target = gzd_pkg::T_CONSUMER;
                    r.out_byte = it.data;
                end
                gzd_pkg::K_INF_END: if (sh_phase == gzd_pkg::PH_BODY) begin
                    sh_phase = gzd_pkg::PH_TRAILER;
                    sh_trailer_cnt = '0;
                    sh_trailer = '0;
                end
                gzd_pkg::K_EOI: begin
                    if (sh_phase == gzd_pkg::PH_HEADER && sh_step == gzd_pkg::HS_FIXED &&
                        sh_fixed_cnt == 0)
                        r.event_res = gzd_pkg::EV_CLEAN_END;
                    else begin
                        sh_failed = 1'b1;
                        r.event_res = gzd_pkg::EV_TRUNC;
                    end
                end
                gzd_pkg::K_INF_ERR: if (sh_phase == gzd_pkg::PH_BODY) begin
                    sh_failed = 1'b1;
                    r.event_res = gzd_pkg::EV_INF_ERR;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // Present one beat, hold it until accepted, then, when the current burst
    // runs out, sometimes pause for a random gap.
    int burst_left;
    int beats_sent;

    task automatic send_beat(logic [2:0] kind, logic [7:0] data);
        gzd_pkg::t_in_item it;
        it.kind = kind;
        it.data = data;
        i_valid <= 1'b1;
        i_item <= it;
        expected_beats.push_back(deframe_beat(it));
        beats_sent++;
        do @(posedge i_clk); while (o_stall);
        if (burst_left > 0) burst_left--;
        else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0) begin
                i_valid <= 1'b0;
                i_item <= gzd_pkg::t_in_item'(11'($urandom));
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    endtask

    // Member builder: header with chosen flags, body bytes, trailer.
    task automatic send_member(logic [7:0] flg, int xlen, int name_len, int body_len,
                               bit bad_crc, bit bad_size, bit bad_hcrc);
        logic [7:0]  b;
        logic [31:0] hcrc, bcrc;
        logic [7:0]  hdr[10];
        hcrc = '0;
        bcrc = '0;
        hdr = '{gzd_pkg::ID1, gzd_pkg::ID2, gzd_pkg::CM_DEFLATE, flg,
                8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom)};
        foreach (hdr[k]) begin
            send_beat(gzd_pkg::K_STREAM, hdr[k]);
            hcrc = crc32_step(hcrc, hdr[k]);
        end
        if (flg[2]) begin
            send_beat(gzd_pkg::K_STREAM, xlen[7:0]);
            send_beat(gzd_pkg::K_STREAM, xlen[15:8]);
            hcrc = crc32_step(crc32_step(hcrc, xlen[7:0]), xlen[15:8]);
            repeat (xlen) begin
                b = 8'($urandom);
                send_beat(gzd_pkg::K_STREAM, b);
                hcrc = crc32_step(hcrc, b);
            end
        end
        for (int f = 3; f <= 4; f++) if (flg[f]) begin
            repeat (name_len) begin
                b = 8'($urandom_range(1, 255));
                send_beat(gzd_pkg::K_STREAM, b);
                hcrc = crc32_step(hcrc, b);
            end
            send_beat(gzd_pkg::K_STREAM, 8'h00);
            hcrc = crc32_step(hcrc, 8'h00);
        end
        if (flg[1]) begin
            if (bad_hcrc) hcrc[0] = ~hcrc[0];
            send_beat(gzd_pkg::K_STREAM, hcrc[7:0]);
            send_beat(gzd_pkg::K_STREAM, hcrc[15:8]);
        end
        for (int k = 0; k < body_len; k++) begin
            // Interleave compressed bytes out and decompressed bytes back.
            if ($urandom_range(0, 1)) send_beat(gzd_pkg::K_STREAM, 8'($urandom));
            b = 8'($urandom);
            send_beat(gzd_pkg::K_DECOMP, b);
            bcrc = crc32_step(bcrc, b);
        end
        send_beat(gzd_pkg::K_INF_END, 8'($urandom));
        if (bad_crc) bcrc ^= 32'h1 << $urandom_range(0, 31);
        for (int k = 0; k < 4; k++) send_beat(gzd_pkg::K_STREAM, bcrc[8*k +: 8]);
        for (int k = 0; k < 4; k++)
            send_beat(gzd_pkg::K_STREAM, 8'((body_len + (bad_size ? 1 : 0)) >> (8 * k)));
    endtask

    // Reset the block and the shadow state; done only at the start.
    task automatic apply_reset();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item <= '0;
        i_stall <= 1'b0;
        reset_shadow();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // Sticky errors need a fresh block; without a second reset, place each
    // error-provoking case last and let everything else precede it.
    task automatic test_directed_members();
        send_beat(gzd_pkg::K_EOI, 8'hff);
        send_beat(gzd_pkg::K_DECOMP, 8'h5a);
        send_beat(gzd_pkg::K_INF_END, 8'h00);
        send_beat(gzd_pkg::K_INF_ERR, 8'h00);
        send_beat(3'd5, 8'h00);
        send_beat(3'd7, 8'hff);
        send_member(8'hff, 0, 0, 1, 0, 0, 0);    // all flags, zero-length extra
        send_member(8'h00, 0, 0, 0, 0, 0, 0);    // bare header, empty body
        send_member(8'h1e, 3, 2, 4, 0, 0, 0);
        send_beat(gzd_pkg::K_EOI, 8'h00);
    endtask

    task automatic test_random_members();
        while (beats_sent < 700) begin
            send_member(8'($urandom) & ($urandom_range(0, 1) ? 8'hff : 8'hfe),
                        ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(0, 4),
                        $urandom_range(0, 5), $urandom_range(0, 12), 0, 0, 0);
            if ($urandom_range(0, 3) == 0) send_beat(gzd_pkg::K_EOI, 8'($urandom));
            if ($urandom_range(0, 4) == 0) send_beat(3'($urandom_range(5, 7)), 8'($urandom));
        end
    endtask

    // Finish with one failing case chosen at random, then noise that must be
    // swallowed by the sticky failure.
    task automatic test_sticky_error();
        case ($urandom_range(0, 5))
            0: send_member(8'h02, 0, 0, 3, 0, 0, 1);
            1: send_member(8'h00, 0, 0, 3, 1, 0, 0);
            2: send_member(8'h00, 0, 0, 3, 0, 1, 0);
            3: begin
                send_beat(gzd_pkg::K_STREAM, gzd_pkg::ID1);
                send_beat(gzd_pkg::K_STREAM, 8'h00);
                repeat (8) send_beat(gzd_pkg::K_STREAM, 8'($urandom));
            end
            4: begin
                repeat (10) send_beat(gzd_pkg::K_STREAM,
                                      (sh_fixed_cnt == 0) ? gzd_pkg::ID1 :
                                      (sh_fixed_cnt == 1) ? gzd_pkg::ID2 :
                                      (sh_fixed_cnt == 2) ? gzd_pkg::CM_DEFLATE : 8'h00);
                send_beat(gzd_pkg::K_INF_ERR, 8'h00);
            end
            default: begin
                send_beat(gzd_pkg::K_STREAM, gzd_pkg::ID1);
                send_beat(gzd_pkg::K_EOI, 8'h00);
            end
        endcase
        repeat (20) send_beat(3'($urandom_range(0, 4)), 8'($urandom));
    endtask

    // Receiver stall pattern: quiet stretches alternate with random stalling.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_noise <= ~stall_noise;
        i_stall <= stall_noise ? ($urandom_range(0, 2) == 0) : 1'b0;
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin
        gzd_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, o_item);
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                if (o_item.target !== want.target) begin
                    $display("%0t: target expected %0d actual %0d",
                             $time, want.target, o_item.target);
                    fail_count++;
                end
                if (o_item.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.out_byte, o_item.out_byte);
                    fail_count++;
                end
                if (o_item.event_res !== want.event_res) begin
                    $display("%0t: event expected %0d actual %0d",
                             $time, want.event_res, o_item.event_res);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        fail_count = 0;
        stall_noise = 1'b0;
        burst_left = 0;
        beats_sent = 0;
        apply_reset();
        test_directed_members();
        test_random_members();
        test_sticky_error();
        i_valid <= 1'b0;
        wait (expected_beats.size() == 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && expected_beats.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
